### hdl/kbsc_pkg.sv
`timescale 1ns / 1ps
package kbsc_pkg;

	// Field and register widths
	localparam int DATA_W      = 8;
	localparam int KEY_W       = 64;
	localparam int MODE_W      = 2;
	localparam int KEYLEN_W    = 4;
	localparam int POS_W       = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int DEF_MAX_KEY = 8;

	// Character constants
	localparam logic [DATA_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [DATA_W-1:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [DATA_W-1:0] CASE_OFFSET  = 8'h20;
	localparam logic [DATA_W-1:0] CHAR_NEWLINE = 8'h0a;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_LOWER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SUB   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 2'd2;

	// Configuration register contents
	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [KEY_W-1:0]    key_chars;
		logic [KEYLEN_W-1:0] key_length;
	} cfg_t;

	// Encoder result handed to the output stage
	typedef struct packed {
		logic [DATA_W-1:0] code;
		logic              extra_nl;
	} enc_res_t;

endpackage

### hdl/kbsc_cfg.sv
`timescale 1ns / 1ps
module kbsc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kbsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kbsc_pkg::KEY_W-1:0]      cfg_data,
	output kbsc_pkg::cfg_t                  cfg
);
	import kbsc_pkg::*;

	cfg_t cfg_q;

	// Register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_LOWER;
			cfg_q.key_chars  <= '0;
			cfg_q.key_length <= KEYLEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:    cfg_q.mode       <= cfg_data[MODE_W-1:0];
				REG_KEY:     cfg_q.key_chars  <= cfg_data;
				REG_KEY_LEN: cfg_q.key_length <= cfg_data[KEYLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/kbsc_encode.sv
`timescale 1ns / 1ps
module kbsc_encode #(
	parameter int MAX_KEY_BYTES = kbsc_pkg::DEF_MAX_KEY
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kbsc_pkg::cfg_t               cfg,
	input  logic [kbsc_pkg::DATA_W-1:0]  data_s1,
	input  logic                         step,
	output kbsc_pkg::enc_res_t           res
);
	import kbsc_pkg::*;

	localparam logic [KEYLEN_W-1:0] MaxLen = KEYLEN_W'(MAX_KEY_BYTES);

	logic [POS_W-1:0]    key_pos_q;
	logic [POS_W-1:0]    key_pos_d;
	logic                keyed;
	logic                is_nl;
	logic [DATA_W-1:0]   key;
	logic [6:0]          sum7;
	logic [KEYLEN_W-1:0] len_eff;
	logic [KEYLEN_W-1:0] pos_inc;

	// Byte transform and key position step
	always_comb begin
		keyed   = (cfg.mode == MODE_ADD) || (cfg.mode == MODE_SUB);
		is_nl   = (data_s1 == CHAR_NEWLINE);
		key     = cfg.key_chars[{key_pos_q, 3'b000} +: DATA_W];
		if (cfg.mode == MODE_ADD) begin
			sum7 = data_s1[6:0] + key[6:0];
		end else begin
			sum7 = data_s1[6:0] - key[6:0];
		end

		// zero length acts as one, oversize saturates
		if (cfg.key_length == '0) begin
			len_eff = KEYLEN_W'(1);
		end else if (cfg.key_length > MaxLen) begin
			len_eff = MaxLen;
		end else begin
			len_eff = cfg.key_length;
		end
		pos_inc = {1'b0, key_pos_q} + KEYLEN_W'(1);

		key_pos_d    = key_pos_q;
		res.extra_nl = 1'b0;
		if (keyed) begin
			res.code = {1'b0, sum7};
			if (is_nl || pos_inc >= len_eff) begin
				key_pos_d = '0;
			end else begin
				key_pos_d = pos_inc[POS_W-1:0];
			end
			res.extra_nl = is_nl;
		end else if (data_s1 >= CHAR_UPPER_A && data_s1 <= CHAR_UPPER_Z) begin
			res.code = data_s1 + CASE_OFFSET;
		end else begin
			res.code = data_s1;
		end
	end

	// Key position advances as each byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= '0;
		end else if (step) begin
			key_pos_q <= key_pos_d;
		end
	end

endmodule

### hdl/kbsc_out.sv
`timescale 1ns / 1ps
module kbsc_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s1,
	input  kbsc_pkg::enc_res_t           res,
	output logic                         step,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [kbsc_pkg::DATA_W-1:0]  out_byte,
	output logic                         last
);
	import kbsc_pkg::*;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_byte_q;
	logic              last_q;
	logic              nl_pend_q;
	logic              out_free;

	// Output register may be loaded when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free && !nl_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			nl_pend_q   <= 1'b0;
		end else if (out_free) begin
			if (nl_pend_q) begin
				out_valid_q <= 1'b1;
				nl_pend_q   <= 1'b0;
			end else begin
				out_valid_q <= valid_s1;
				nl_pend_q   <= valid_s1 && res.extra_nl;
			end
		end
	end

	// Payload: trailing newline, or the encoded byte
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (nl_pend_q) begin
				out_byte_q <= CHAR_NEWLINE;
				last_q     <= 1'b1;
			end else if (valid_s1) begin
				out_byte_q <= res.code;
				last_q     <= !res.extra_nl;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// A pending newline sits behind a non-final byte
	a_pend_holds: assert property (@(posedge clk) disable iff (!arst_n)
		nl_pend_q |-> (out_valid_q && !last_q))
		else $error("pending newline without a non-final byte in the output register");

	// Non-final byte taken is followed by the trailing newline
	a_nl_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !last_q) |=>
		(out_valid_q && last_q && out_byte_q == CHAR_NEWLINE))
		else $error("trailing newline missing after non-final byte");

	// No new byte is taken while the trailing newline is owed
	a_no_step_pend: assert property (@(posedge clk) disable iff (!arst_n)
		nl_pend_q |-> !step)
		else $error("input advanced while trailing newline pending");

endmodule

### hdl/keyed_byte_shift_cipher_top.sv
`timescale 1ns / 1ps
// An input byte passes through the input register and then the result register on its way to out_byte.
// Throughput: one byte per cycle while out_stall is low; a newline in a keyed mode holds the input
//   while the result register sends the trailing newline.
// Reset (arst_n, asynchronous, active low): mode 0, key bytes 0, key length 1,
//   key position 0, both registers empty.
module keyed_byte_shift_cipher_top #(
	parameter int MAX_KEY_BYTES = kbsc_pkg::DEF_MAX_KEY
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kbsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kbsc_pkg::KEY_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [kbsc_pkg::DATA_W-1:0]     in_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kbsc_pkg::DATA_W-1:0]     out_byte,
	output logic                            last
);
	import kbsc_pkg::*;

	cfg_t              cfg;
	enc_res_t          res;
	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              step;

	kbsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_byte;
		end
	end

	kbsc_encode #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_encode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.data_s1 (data_s1),
		.step    (step),
		.res     (res)
	);

	kbsc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.step      (step),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

### tb/sv/keyed_byte_shift_cipher_checker.sv
`timescale 1ns / 1ps
module keyed_byte_shift_cipher_checker #(
	parameter int MAX_KEY_BYTES = kbsc_pkg::DEF_MAX_KEY
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kbsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kbsc_pkg::KEY_W-1:0]      cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [kbsc_pkg::DATA_W-1:0]     in_byte,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [kbsc_pkg::DATA_W-1:0]     out_byte,
	input  logic                            last,
	output int                              fail_count,
	output int                              pending,
	output int                              results_seen
);
	import kbsc_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] byte_val;
		logic              is_last;
	} cipher_result_t;

	// Shadow of the register file and key pointer
	logic [MODE_W-1:0]   cur_mode   = MODE_LOWER;
	logic [KEY_W-1:0]    key_bytes  = '0;
	logic [KEYLEN_W-1:0] key_len    = 4'd1;
	logic [POS_W-1:0]    key_pos    = '0;

	cipher_result_t cipher_out_q[$];
	cipher_result_t want;

	// Work out the output bytes for one accepted input byte
	task automatic predict_cipher_output(input logic [DATA_W-1:0] raw);
		logic [DATA_W-1:0]   key;
		logic [DATA_W-1:0]   code;
		logic [KEYLEN_W-1:0] span;
		logic [KEYLEN_W-1:0] nxt;
		if (cur_mode != MODE_ADD && cur_mode != MODE_SUB) begin
			// lowercase pass, spare mode code included
			code = raw;
			if (raw >= CHAR_UPPER_A && raw <= CHAR_UPPER_Z)
				code = raw + CASE_OFFSET;
			cipher_out_q.push_back('{code, 1'b1});
		end else begin
			key = key_bytes[8*key_pos +: 8];
			if (cur_mode == MODE_ADD)
				code = (raw + key) & 8'h7f;
			else
				code = (raw - key) & 8'h7f;
			// zero length counts as one, oversize saturates
			span = key_len;
			if (span == 0)
				span = 4'd1;
			if (span > MAX_KEY_BYTES)
				span = KEYLEN_W'(MAX_KEY_BYTES);
			nxt = {1'b0, key_pos} + 4'd1;
			key_pos = (nxt >= span) ? '0 : nxt[POS_W-1:0];
			if (raw == CHAR_NEWLINE) begin
				key_pos = '0;
				cipher_out_q.push_back('{code, 1'b0});
				cipher_out_q.push_back('{CHAR_NEWLINE, 1'b1});
			end else begin
				cipher_out_q.push_back('{code, 1'b1});
			end
		end
	endtask

	// Track writes, predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode  = MODE_LOWER;
			key_bytes = '0;
			key_len   = 4'd1;
			key_pos   = '0;
			cipher_out_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:    cur_mode  = cfg_data[MODE_W-1:0];
					REG_KEY:     key_bytes = cfg_data;
					REG_KEY_LEN: key_len   = cfg_data[KEYLEN_W-1:0];
					default:     ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_cipher_output(in_byte);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (cipher_out_q.size() == 0) begin
					$error("unexpected transaction: out_byte %02h last %0b", out_byte, last);
					fail_count++;
				end else begin
					want = cipher_out_q.pop_front();
					if (want.byte_val !== out_byte) begin
						$error("out_byte: expected %02h, actual %02h", want.byte_val, out_byte);
						fail_count++;
					end
					if (want.is_last !== last) begin
						$error("last: expected %0b, actual %0b", want.is_last, last);
						fail_count++;
					end
				end
			end
			pending <= cipher_out_q.size();
		end
	end

endmodule

### tb/sv/keyed_byte_shift_cipher_top_test.sv
`timescale 1ns / 1ps
module keyed_byte_shift_cipher_top_test;
	import kbsc_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int MAX_WAIT    = 13;
	localparam int BYTE_TARGET = 1950;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
	logic [KEY_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [DATA_W-1:0]    in_byte   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [DATA_W-1:0]    out_byte;
	logic                 last;

	logic quiet_link   = 1'b0;
	int   bytes_sent   = 0;
	int   config_count = 0;
	int   fail_count;
	int   pending;
	int   results_seen;

	keyed_byte_shift_cipher_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .last(last)
	);

	keyed_byte_shift_cipher_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .last(last),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int draw_wait();
		return quiet_link ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// One input transaction, after a random gap
	task automatic send_byte(input logic [DATA_W-1:0] b);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	// Hold off until every predicted result has been taken
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Caller lowers cfg_we after the last write of a batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Full register set; spare bits carry noise, the unused index gets junk
	task automatic set_config(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] key,
			input logic [KEYLEN_W-1:0] len);
		logic [KEY_W-1:0] noise;
		noise = {$urandom, $urandom};
		write_reg(REG_MODE, {noise[KEY_W-1:MODE_W], m});
		write_reg(REG_KEY, key);
		noise = {$urandom, $urandom};
		write_reg(REG_KEY_LEN, {noise[KEY_W-1:KEYLEN_W], len});
		write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
		config_count++;
	endtask

	// Result side: random stall ahead of each transaction
	initial begin
		int hold;
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		logic [MODE_W-1:0]   rand_mode;
		logic [KEY_W-1:0]    rand_key;
		logic [KEYLEN_W-1:0] rand_len;
		int                  phase_n;
		int                  phase_len;
		int                  pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: lowercase pass, letter boundaries and byte extremes
		send_byte(CHAR_UPPER_A);
		send_byte(CHAR_UPPER_Z);
		send_byte(CHAR_UPPER_A - 8'd1);
		send_byte(CHAR_UPPER_Z + 8'd1);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(CHAR_NEWLINE);

		// Add with key bytes that have the top bit set, newline mid-key
		wait_idle();
		set_config(MODE_ADD, 64'h0102_0304_807f_ff80, 4'd8);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h7f);
		send_byte(CHAR_NEWLINE);
		send_byte(8'h80);

		// Subtract with zero key length, all-ones key
		wait_idle();
		set_config(MODE_SUB, '1, 4'd0);
		send_byte(8'h00);
		send_byte(CHAR_NEWLINE);
		send_byte(8'h7f);

		// Spare mode code with oversize length
		wait_idle();
		set_config(MODE_SPARE, 64'h1122_3344_5566_7788, 4'd15);
		send_byte(8'h51);
		send_byte(CHAR_NEWLINE);

		// Pointer left beyond a shortened key
		wait_idle();
		set_config(MODE_SUB, 64'h4030_2010_0807_0605, 4'd8);
		repeat (5) send_byte(8'h55);
		wait_idle();
		write_reg(REG_KEY_LEN, {{(KEY_W-KEYLEN_W){1'b1}}, 4'd3});
		cfg_we <= 1'b0;
		send_byte(8'h55);
		send_byte(8'h55);

		// Random phases, each with its own settings and link behaviour
		phase_n = 0;
		while (bytes_sent < BYTE_TARGET) begin
			wait_idle();
			pick = $urandom_range(0, 9);
			if (pick == 0)
				rand_mode = MODE_LOWER;
			else if (pick == 1)
				rand_mode = MODE_SPARE;
			else if (pick < 6)
				rand_mode = MODE_ADD;
			else
				rand_mode = MODE_SUB;
			rand_key = {$urandom, $urandom};
			rand_len = KEYLEN_W'($urandom_range(1, 8));
			case (phase_n % 6)
				0: begin
					rand_key = '0;
					rand_len = 4'd1;
				end
				1: begin
					rand_key = '1;
					rand_len = 4'd8;
				end
				2: rand_len = 4'd0;
				3: rand_len = 4'd15;
				4: rand_len = KEYLEN_W'($urandom_range(0, 15));
				default: ;
			endcase
			set_config(rand_mode, rand_key, rand_len);
			quiet_link = ($urandom_range(0, 3) == 0);
			phase_len  = $urandom_range(20, 120);
			repeat (phase_len) begin
				pick = $urandom_range(0, 7);
				case (pick)
					0: send_byte(CHAR_NEWLINE);
					1: send_byte(DATA_W'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z)));
					default: send_byte(DATA_W'($urandom_range(0, 255)));
				endcase
				// occasional full drain mid-phase
				if ($urandom_range(0, 99) == 0)
					wait_idle();
			end
			phase_n++;
		end

		quiet_link = 1'b0;
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes under %0d register settings, %0d output transactions checked.",
			bytes_sent, config_count, results_seen);
		$display("Modes incl. the spare code, key lengths 0..15, newline pairs, stalls both sides.");
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
